@@ rtl/ckb_pkg.sv @@
// ckb_pkg: shared types and constants for the PPM colour-key blitter.
// No dependencies; imported by every module of the block.
package ckb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 800;
    localparam int SCREEN_HEIGHT_DEF = 480;

    // Screen coordinates never exceed 1023 in any legal configuration.
    localparam int COORD_W = 10;
    localparam int ADDR_W  = 19;
    localparam int WORD_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int JOBQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_COLUMN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_ROW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOUR   = 2'd2;

    typedef enum logic [1:0] {
        KIND_PIXEL        = 2'd0,
        KIND_FINISHED     = 2'd1,
        KIND_BAD_MAGIC    = 2'd2,
        KIND_BAD_POSITION = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  pixel_address;
        logic [WORD_W-1:0]  pixel_word;
        logic               end_of_run;
    } t_out;

    typedef struct packed {
        logic [9:0]        origin_column;
        logic [8:0]        origin_row;
        logic [WORD_W-1:0] fill_colour;
    } t_cfg;

    // Work handed from the parser to the write engine for one request.
    typedef struct packed {
        logic               has_pix;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [WORD_W-1:0]  word;
        logic               has_tail;
        t_kind              tail_kind;
    } t_job;

endpackage

@@ rtl/ckb_fifo.sv @@
// ckb_fifo: small register queue with full/empty flags.
// Depends on ckb_pkg for default depth.
module ckb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ckb_pkg::JOBQ_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    import ckb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

@@ rtl/ckb_front.sv @@
// ckb_front: PPM header parser and pixel classifier, one byte per cycle while i_accept is high.
// Depends on ckb_pkg; emits one t_job per byte that causes a result.
module ckb_front #(
    parameter int SCREEN_WIDTH  = ckb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ckb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  ckb_pkg::t_in  i_in,
    input  ckb_pkg::t_cfg i_cfg,
    output logic          o_job_valid,
    output ckb_pkg::t_job o_job
);
    import ckb_pkg::*;

    typedef enum logic [7:0] {
        PH_MAGIC      = 8'b0000_0001,
        PH_WIDTH      = 8'b0000_0010,
        PH_WIDTH_SEP  = 8'b0000_0100,
        PH_HEIGHT     = 8'b0000_1000,
        PH_HEIGHT_SEP = 8'b0001_0000,
        PH_MAXVAL     = 8'b0010_0000,
        PH_PIXELS     = 8'b0100_0000,
        PH_DRAIN      = 8'b1000_0000
    } t_phase;

    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_6 = 8'h36;

    t_phase             r_phase, n_phase;
    logic [1:0]         r_cnt, n_cnt;
    logic [COORD_W-1:0] r_width, n_width;
    logic [COORD_W-1:0] r_height, n_height;
    logic [1:0]         r_tpos, n_tpos;
    logic [15:0]        r_held, n_held;
    logic [COORD_W-1:0] r_scol, n_scol;
    logic [COORD_W-1:0] r_srow, n_srow;

    logic [7:0]         b;
    logic               silent;
    logic [COORD_W:0]   col, row;
    logic [COORD_W-1:0] scol_inc;
    logic [7:0]         red, grn;
    t_job               job;

    function automatic logic is_space(input logic [7:0] v);
        return (v == 8'h20) || (v >= 8'h09 && v <= 8'h0D);
    endfunction

    // v*10 + low nibble, wrapped to the coordinate width.
    function automatic logic [COORD_W-1:0] dim_next(input logic [COORD_W-1:0] v,
                                                    input logic [7:0] d);
        logic [COORD_W+2:0] acc;
        acc = {v, 3'b000} + {2'b00, v, 1'b0} + (COORD_W+3)'(d[3:0]);
        return acc[COORD_W-1:0];
    endfunction

    assign b        = i_in.source_byte;
    assign red      = r_held[15:8];
    assign grn      = r_held[7:0];
    assign col      = (COORD_W+1)'(i_cfg.origin_column) + (COORD_W+1)'(r_scol);
    assign row      = (COORD_W+1)'(i_cfg.origin_row) + (COORD_W+1)'(r_srow);
    assign scol_inc = r_scol + 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_width  = r_width;
        n_height = r_height;
        n_tpos   = r_tpos;
        n_held   = r_held;
        n_scol   = r_scol;
        n_srow   = r_srow;
        silent   = (r_phase == PH_DRAIN);
        job      = '0;
        job.tail_kind = KIND_FINISHED;
        job.row  = row[COORD_W-1:0];
        job.col  = col[COORD_W-1:0];

        unique case (r_phase)
            PH_MAGIC: begin
                if (r_cnt == 2'd0 &&
                    ((COORD_W+1)'(i_cfg.origin_row) > (COORD_W+1)'(SCREEN_HEIGHT) ||
                     (COORD_W+1)'(i_cfg.origin_column) > (COORD_W+1)'(SCREEN_WIDTH))) begin
                    job.has_tail  = 1'b1;
                    job.tail_kind = KIND_BAD_POSITION;
                end else if ((r_cnt == 2'd0 && b != CH_P) ||
                             (r_cnt == 2'd1 && b != CH_6)) begin
                    job.has_tail  = 1'b1;
                    job.tail_kind = KIND_BAD_MAGIC;
                end else if (r_cnt >= 2'd2) begin
                    n_cnt   = 2'd0;
                    n_phase = PH_WIDTH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (job.has_tail) begin
                    n_phase = PH_DRAIN;
                    silent  = 1'b1;
                end
            end
            PH_WIDTH: begin
                if (is_space(b)) begin
                    n_cnt   = 2'd0;
                    n_phase = PH_HEIGHT;
                end else begin
                    n_width = dim_next(r_width, b);
                    if (r_cnt == 2'd2) begin
                        n_cnt   = 2'd0;
                        n_phase = PH_WIDTH_SEP;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            PH_WIDTH_SEP: n_phase = PH_HEIGHT;
            PH_HEIGHT: begin
                if (is_space(b)) begin
                    n_cnt   = 2'd0;
                    n_phase = PH_MAXVAL;
                end else begin
                    n_height = dim_next(r_height, b);
                    if (r_cnt == 2'd2) begin
                        n_cnt   = 2'd0;
                        n_phase = PH_HEIGHT_SEP;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            PH_HEIGHT_SEP: n_phase = PH_MAXVAL;
            PH_MAXVAL: begin
                if (is_space(b)) begin
                    n_phase = PH_PIXELS;
                end
            end
            PH_PIXELS: begin
                if (r_tpos == 2'd0) begin
                    n_held = {b, 8'h00};
                    n_tpos = 2'd1;
                end else if (r_tpos == 2'd1) begin
                    n_held = {r_held[15:8], b};
                    n_tpos = 2'd2;
                end else begin
                    n_tpos = 2'd0;
                    if (r_srow < r_height && r_scol < r_width) begin
                        if (scol_inc >= r_width) begin
                            n_scol = '0;
                            n_srow = r_srow + 1'b1;
                        end else begin
                            n_scol = scol_inc;
                        end
                        // clip, then drop pure white (colour key)
                        if (col < (COORD_W+1)'(SCREEN_WIDTH) &&
                            row < (COORD_W+1)'(SCREEN_HEIGHT) &&
                            !(red == 8'hFF && grn == 8'hFF && b == 8'hFF)) begin
                            job.has_pix = 1'b1;
                            if (red == 8'h00 && grn == 8'h00 && b == 8'h00) begin
                                job.word = i_cfg.fill_colour;
                            end else begin
                                job.word = {grn[4:2], b[7:3], red[7:3], grn[7:5]};
                            end
                        end
                    end
                end
            end
            PH_DRAIN: ;
            default: n_phase = PH_MAGIC;
        endcase

        if (i_in.last_byte) begin
            if (!silent) begin
                job.has_tail  = 1'b1;
                job.tail_kind = KIND_FINISHED;
            end
            n_phase  = PH_MAGIC;
            n_cnt    = '0;
            n_width  = '0;
            n_height = '0;
            n_tpos   = '0;
            n_held   = '0;
            n_scol   = '0;
            n_srow   = '0;
        end
    end

    assign o_job       = job;
    assign o_job_valid = i_accept && (job.has_pix || job.has_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC;
            r_cnt    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_tpos   <= '0;
            r_held   <= '0;
            r_scol   <= '0;
            r_srow   <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_width  <= n_width;
            r_height <= n_height;
            r_tpos   <= n_tpos;
            r_held   <= n_held;
            r_scol   <= n_scol;
            r_srow   <= n_srow;
        end
    end

    a_drain_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_DRAIN) |-> !o_job_valid)
        else $error("request issued while draining after an error");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("header byte count out of range");
    a_error_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_valid && job.has_tail && job.tail_kind != KIND_FINISHED &&
         !i_in.last_byte) |=> r_phase == PH_DRAIN)
        else $error("error request did not enter drain");

endmodule

@@ rtl/ckb_back.sv @@
// ckb_back: write engine; turns parser requests into framebuffer results.
// Depends on ckb_pkg; registers row*SCREEN_WIDTH, then adds the column.
module ckb_back #(
    parameter int SCREEN_WIDTH = ckb_pkg::SCREEN_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_avail,
    input  ckb_pkg::t_job i_job,
    output logic          o_job_pop,
    input  logic          i_out_full,
    output logic          o_out_push,
    output ckb_pkg::t_out o_out
);
    import ckb_pkg::*;

    localparam int PROD_W = 2 * COORD_W;

    logic              r_a_valid;
    logic              r_a_pix_pend;
    t_job              r_a_job;
    logic [PROD_W-1:0] r_a_prod;

    logic              a_fire, a_done, load;
    logic [PROD_W:0]   addr_sum;
    t_out              res;

    assign a_fire = r_a_valid && !i_out_full;
    assign a_done = a_fire && !(r_a_pix_pend && r_a_job.has_tail);
    assign load   = i_job_avail && (!r_a_valid || a_done);
    assign o_job_pop = load;

    assign addr_sum = (PROD_W+1)'(r_a_prod) + (PROD_W+1)'(r_a_job.col);

    always_comb begin
        res = '0;
        if (r_a_pix_pend) begin
            res.kind          = KIND_PIXEL;
            res.pixel_address = addr_sum[ADDR_W-1:0];
            res.pixel_word    = r_a_job.word;
            res.end_of_run    = !r_a_job.has_tail;
        end else begin
            res.kind          = r_a_job.tail_kind;
            res.end_of_run    = 1'b1;
        end
    end

    assign o_out      = res;
    assign o_out_push = a_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_a_pix_pend <= 1'b0;
        end else if (load) begin
            r_a_valid    <= 1'b1;
            r_a_pix_pend <= i_job.has_pix;
        end else if (a_done) begin
            r_a_valid    <= 1'b0;
            r_a_pix_pend <= 1'b0;
        end else if (a_fire) begin
            r_a_pix_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_a_job  <= i_job;
            r_a_prod <= PROD_W'(i_job.row) * PROD_W'(SCREEN_WIDTH);
        end
    end

    a_pend_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_pix_pend |-> r_a_valid)
        else $error("pixel pending in empty stage");
    a_stage_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_a_pix_pend || r_a_job.has_tail))
        else $error("stage holds a request with nothing to write");
    a_mid_is_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_push && !o_out.end_of_run) |-> o_out.kind == KIND_PIXEL)
        else $error("non-final result is not a pixel write");
    a_tail_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_push && !o_out.end_of_run) |=> (r_a_valid && !r_a_pix_pend))
        else $error("tail result lost after pixel write");

endmodule

@@ rtl/ppm_colour_key_blitter_top.sv @@
// PPM P6 colour-key blitter: parses the header, clips, keys and writes byte-swapped RGB565.
// Throughput: one source byte per cycle while full is low; a last byte with a pixel gives two results.
// A taken byte's request is registered in the request queue, then in the multiply
// register of the write engine, before its result enters the output queue.
// Reset (synchronous, i_rst_n low): registers to 0, parser to magic, queues empty.
// Depends on ckb_pkg, ckb_front, ckb_fifo, ckb_back.
module ppm_colour_key_blitter_top #(
    parameter int SCREEN_WIDTH  = ckb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ckb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // source side
    input  logic                           push,
    output logic                           full,
    input  ckb_pkg::t_in                   i_in,
    // result side
    output logic                           empty,
    input  logic                           pop,
    output ckb_pkg::t_out                  o_out,
    // configuration
    input  logic                           i_cfg_wr_en,
    input  logic [ckb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ckb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ckb_pkg::*;

    // Configuration registers, used live by the parser.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_ORIGIN_COLUMN: r_cfg.origin_column <= i_cfg_data[9:0];
                REG_ORIGIN_ROW:    r_cfg.origin_row    <= i_cfg_data[8:0];
                REG_FILL_COLOUR:   r_cfg.fill_colour   <= i_cfg_data[WORD_W-1:0];
                default: ;   // unmapped index: ignored
            endcase
        end
    end

    // Front: the parser takes a byte whenever the request queue has room.
    logic accept;
    logic job_push;
    t_job job_in;
    logic jq_full, jq_empty, jq_pop;
    t_job jq_head;

    assign full   = jq_full;
    assign accept = push && !jq_full;

    ckb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_job_valid (job_push),
        .o_job       (job_in)
    );

    // Request queue decouples parsing from the write engine.
    ckb_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_wdata (job_in),
        .o_full  (jq_full),
        .i_pop   (jq_pop),
        .o_rdata (jq_head),
        .o_empty (jq_empty)
    );

    // Back: one result per cycle into the output queue while it has room.
    logic oq_full, oq_push;
    t_out oq_in;

    ckb_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_avail (!jq_empty),
        .i_job       (jq_head),
        .o_job_pop   (jq_pop),
        .i_out_full  (oq_full),
        .o_out_push  (oq_push),
        .o_out       (oq_in)
    );

    // Output queue lets the engine keep going while a result waits.
    ckb_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_wdata (oq_in),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_rdata (o_out),
        .o_empty (empty)
    );

endmodule

@@ dv/testbench.sv @@
// testbench: self-checking bench for ppm_colour_key_blitter_top.
// Streams hand-made and random PPM P6 files through the queue ports and predicts
// every write and status result in a small tracker class. Depends on ckb_pkg and ppm_colour_key_blitter_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ckb_pkg::*;

    localparam int SCR_W = SCREEN_WIDTH_DEF;
    localparam int SCR_H = SCREEN_HEIGHT_DEF;

    // Magic bytes of a P6 file
    localparam logic [7:0] MAGIC_P = 8'h50;
    localparam logic [7:0] MAGIC_6 = 8'h36;

    localparam int MAX_GAP      = 18;
    localparam int NUM_REQUESTS = 800;
    localparam int SETTLE_CYCLES = 4;   // a byte with no result may still be in flight
    localparam int DRAIN_CYCLES  = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int MAX_PRINTED   = 50;

    // Parser phases of the header/pixel walk
    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_WIDTH,
        PH_WIDTH_SEP,
        PH_HEIGHT,
        PH_HEIGHT_SEP,
        PH_MAXVAL,
        PH_PIXELS,
        PH_DRAIN
    } phase_e;

    // Mirrors the registers and the parser, and holds the writes still owed
    // by the block, oldest first.
    class blit_tracker;
        t_out       expected_writes[$];
        int         errors;

        logic [9:0]  org_col;
        logic [8:0]  org_row;
        logic [15:0] fill;

        phase_e      phase;
        logic [1:0]  hdr_cnt;
        logic [9:0]  img_w;
        logic [9:0]  img_h;
        logic [1:0]  tri_pos;
        logic [15:0] held_rg;
        logic [9:0]  src_col;
        logic [9:0]  src_row;

        function new();
            errors  = 0;
            org_col = '0;
            org_row = '0;
            fill    = '0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase   = PH_MAGIC;
            hdr_cnt = '0;
            img_w   = '0;
            img_h   = '0;
            tri_pos = '0;
            held_rg = '0;
            src_col = '0;
            src_row = '0;
        endfunction

        function void mirror_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ORIGIN_COLUMN: org_col = data[9:0];
                REG_ORIGIN_ROW:    org_row = data[8:0];
                REG_FILL_COLOUR:   fill    = data;
                default: ;
            endcase
        endfunction

        function bit is_ws(logic [7:0] b);
            return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
        endfunction

        // One byte of a dimension; returns 1 when the field ends on whitespace.
        function bit take_dim_byte(inout logic [9:0] v, input logic [7:0] b,
                                   input phase_e sep_phase);
            if (is_ws(b))
                return 1'b1;
            v = 10'(v * 10 + b[3:0]);
            hdr_cnt = hdr_cnt + 2'd1;
            if (hdr_cnt == 2'd3) begin
                hdr_cnt = '0;
                phase   = sep_phase;
            end
            return 1'b0;
        endfunction

        // Works out the results of one accepted request and queues them.
        function void predict_writes(t_in req);
            t_out       res[$];
            t_out       r;
            logic [7:0] b;
            logic [7:0] red;
            logic [7:0] grn;
            int         col;
            int         row;
            bit         silent;

            b      = req.source_byte;
            silent = (phase == PH_DRAIN);
            r      = '0;
            case (phase)
                PH_MAGIC: begin
                    if (hdr_cnt == 0 && (org_row > SCR_H || org_col > SCR_W)) begin
                        r.kind = KIND_BAD_POSITION;
                        res.push_back(r);
                    end else if ((hdr_cnt == 0 && b != MAGIC_P) ||
                                 (hdr_cnt == 1 && b != MAGIC_6)) begin
                        r.kind = KIND_BAD_MAGIC;
                        res.push_back(r);
                    end else if (hdr_cnt >= 2) begin
                        hdr_cnt = '0;
                        phase   = PH_WIDTH;
                    end else begin
                        hdr_cnt++;
                    end
                    if (res.size() > 0) begin
                        phase  = PH_DRAIN;
                        silent = 1'b1;
                    end
                end
                PH_WIDTH: begin
                    if (take_dim_byte(img_w, b, PH_WIDTH_SEP)) begin
                        hdr_cnt = '0;
                        phase   = PH_HEIGHT;
                    end
                end
                PH_WIDTH_SEP: phase = PH_HEIGHT;
                PH_HEIGHT: begin
                    if (take_dim_byte(img_h, b, PH_HEIGHT_SEP)) begin
                        hdr_cnt = '0;
                        phase   = PH_MAXVAL;
                    end
                end
                PH_HEIGHT_SEP: phase = PH_MAXVAL;
                PH_MAXVAL: begin
                    if (is_ws(b))
                        phase = PH_PIXELS;
                end
                PH_PIXELS: begin
                    if (tri_pos == 0) begin
                        held_rg = {b, 8'h00};
                        tri_pos = 2'd1;
                    end else if (tri_pos == 1) begin
                        held_rg[7:0] = b;
                        tri_pos = 2'd2;
                    end else begin
                        tri_pos = '0;
                        // surplus triples fall out here
                        if (src_row < img_h && src_col < img_w) begin
                            red = held_rg[15:8];
                            grn = held_rg[7:0];
                            col = int'(org_col) + int'(src_col);
                            row = int'(org_row) + int'(src_row);
                            src_col = src_col + 10'd1;
                            if (src_col >= img_w) begin
                                src_col = '0;
                                src_row = src_row + 10'd1;
                            end
                            // clipped or white: nothing written
                            if (col < SCR_W && row < SCR_H &&
                                !(red == 8'hFF && grn == 8'hFF && b == 8'hFF)) begin
                                r.kind          = KIND_PIXEL;
                                r.pixel_address = ADDR_W'(row * SCR_W + col);
                                if (red == 0 && grn == 0 && b == 0)
                                    r.pixel_word = fill;
                                else
                                    r.pixel_word = {grn[4:2], b[7:3], red[7:3], grn[7:5]};
                                res.push_back(r);
                            end
                        end
                    end
                end
                default: ;
            endcase

            if (req.last_byte) begin
                if (!silent) begin
                    r      = '0;
                    r.kind = KIND_FINISHED;
                    res.push_back(r);
                end
                clear_parse();
            end
            if (res.size() > 0)
                res[res.size()-1].end_of_run = 1'b1;
            foreach (res[i])
                expected_writes.push_back(res[i]);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("%0t MISMATCH %s", $realtime, msg);
        endtask

        task check_result(t_out got);
            t_out want;
            if (expected_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d addr=%0d word=%h",
                                          got.kind, got.pixel_address, got.pixel_word));
                return;
            end
            want = expected_writes.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
            if (got.pixel_address !== want.pixel_address)
                report_mismatch($sformatf("pixel_address got %0d want %0d",
                                          got.pixel_address, want.pixel_address));
            if (got.pixel_word !== want.pixel_word)
                report_mismatch($sformatf("pixel_word got %h want %h",
                                          got.pixel_word, want.pixel_word));
            if (got.end_of_run !== want.end_of_run)
                report_mismatch($sformatf("end_of_run got %b want %b",
                                          got.end_of_run, want.end_of_run));
        endtask

        task check_leftovers();
            if (expected_writes.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          expected_writes.size()));
        endtask
    endclass

    // ---------------------------------------------------------------------
    // Clock, reset and DUT
    // ---------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    t_in                   i_in        = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    t_out                  o_out;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    ppm_colour_key_blitter_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    blit_tracker sb;

    logic [7:0] file_bytes[$];   // file being built for the next send
    bit         src_burst;       // source side sends back to back when set
    bit         sink_burst;      // result side pops every cycle when set
    int         sent_count = 0;

    // ---------------------------------------------------------------------
    // Monitors: both handshakes are sampled at the rising edge, so values
    // seen here are the ones the DUT saw.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full)
            sb.predict_writes(i_in);
        if (i_rst_n && pop && !empty)
            sb.check_result(o_out);
    end

    // ---------------------------------------------------------------------
    // Result side: random stall before every pop, with burst stretches
    // ---------------------------------------------------------------------
    initial begin
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                sink_burst = !sink_burst;
            gap = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // ---------------------------------------------------------------------
    // Source side drivers
    // ---------------------------------------------------------------------

    // One request; push stays high when the next one follows with no gap.
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= '{source_byte: b, last_byte: last};
        do @(posedge i_clk); while (full);
        sent_count++;
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // Wait for every owed result, then let silent bytes in flight settle.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_writes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write enable is left high here; the caller drops it after the group.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.mirror_reg(idx, data);
    endtask

    task automatic program_registers(int col, int row, int fill);
        write_reg(REG_ORIGIN_COLUMN, CFG_DATA_W'(col));
        write_reg(REG_ORIGIN_ROW, CFG_DATA_W'(row));
        write_reg(REG_FILL_COLOUR, CFG_DATA_W'(fill));
        i_cfg_wr_en <= 1'b0;
    endtask

    // Origins favor the screen edges so clipping is hit often; out-of-range
    // origins are kept rare since they reject whole files.
    task automatic random_config();
        int col;
        int row;
        int fill;
        case ($urandom_range(0, 15))
            0:       col = 0;
            1:       col = SCR_W;
            2:       col = $urandom_range(SCR_W + 1, 1023);
            3:       col = 1023;
            4, 5, 6: col = $urandom_range(SCR_W - 6, SCR_W - 1);
            default: col = $urandom_range(0, SCR_W - 1);
        endcase
        case ($urandom_range(0, 15))
            0:       row = 0;
            1:       row = SCR_H;
            2:       row = $urandom_range(SCR_H + 1, 511);
            3:       row = 511;
            4, 5, 6: row = $urandom_range(SCR_H - 4, SCR_H - 1);
            default: row = $urandom_range(0, SCR_H - 1);
        endcase
        case ($urandom_range(0, 3))
            0:       fill = 0;
            1:       fill = 16'hFFFF;
            default: fill = $urandom_range(0, 16'hFFFF);
        endcase
        program_registers(col, row, fill);
    endtask

    // ---------------------------------------------------------------------
    // File generation
    // ---------------------------------------------------------------------
    function automatic logic [7:0] random_ws();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? 8'h20 : 8'h09 + 8'(k);
    endfunction

    function automatic logic [7:0] random_non_ws();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D))
            b = "5";
        return b;
    endfunction

    // Decimal field with the odd empty field, junk digit, or a random
    // byte eaten as separator after three digits.
    function automatic void add_dim(int value);
        string digits;
        int    pick;
        pick   = $urandom_range(0, 11);
        digits = $sformatf("%0d", value);
        if (pick == 0) begin
            file_bytes.push_back(random_ws());
            return;
        end
        for (int i = 0; i < digits.len(); i++)
            file_bytes.push_back((pick == 1 && i == 0) ? random_non_ws() : digits[i]);
        if (digits.len() == 3 && $urandom_range(0, 1))
            file_bytes.push_back(8'($urandom_range(0, 255)));
        else
            file_bytes.push_back(random_ws());
    endfunction

    task automatic make_file();
        int         shape;
        int         w;
        int         h;
        int         ntri;
        logic [7:0] red;
        logic [7:0] grn;
        logic [7:0] blu;

        file_bytes.delete();
        shape = $urandom_range(0, 15);
        // plain noise
        if (shape == 0) begin
            repeat ($urandom_range(1, 8))
                file_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        // second magic byte mostly wrong, tail drained silently
        if (shape == 1) begin
            file_bytes.push_back(MAGIC_P);
            file_bytes.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 4))
                file_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end

        file_bytes.push_back(MAGIC_P);
        file_bytes.push_back(MAGIC_6);
        file_bytes.push_back(8'($urandom_range(0, 255)));   // third magic byte is not checked
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 999) : $urandom_range(0, 5);
        h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 999) : $urandom_range(0, 4);
        add_dim(w);
        add_dim(h);
        repeat ($urandom_range(1, 3))
            file_bytes.push_back(random_non_ws());
        file_bytes.push_back(random_ws());

        // large images are cut short by the last byte
        ntri = (w * h <= 20) ? w * h : $urandom_range(1, 20);
        if ($urandom_range(0, 5) == 0)
            ntri += $urandom_range(1, 3);
        repeat (ntri) begin
            case ($urandom_range(0, 3))
                0:       {red, grn, blu} = 24'hFFFFFF;
                1:       {red, grn, blu} = 24'h000000;
                default: {red, grn, blu} = 24'($urandom);
            endcase
            file_bytes.push_back(red);
            file_bytes.push_back(grn);
            file_bytes.push_back(blu);
        end

        // partial final triple
        if ($urandom_range(0, 5) == 0 && file_bytes.size() > 4)
            repeat ($urandom_range(1, 2)) void'(file_bytes.pop_back());
        // file broken off anywhere, header included
        if (shape == 2) begin
            w = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > w)
                void'(file_bytes.pop_back());
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        int wait_cnt;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bad magic on the first byte, reset registers
        file_bytes = {8'h00};
        send_file();
        // bad magic on the second byte, rest of the file drained
        file_bytes = {MAGIC_P, "5", 8'hFF};
        send_file();

        // 3x1 image at the bottom-right corner: white, black and a colour
        wait_idle();
        program_registers(SCR_W - 3, SCR_H - 1, 16'hA5C3);
        file_bytes = {MAGIC_P, MAGIC_6, 8'h0A, "3", " ", "1", 8'h0D, "2", "5", "5", 8'h0A,
                      8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h12, 8'hE7, 8'hF8};
        send_file();

        // origin past the right edge rejects the file at its first byte
        wait_idle();
        program_registers(SCR_W + 1, 0, 16'hFFFF);
        file_bytes = {MAGIC_P};
        send_file();

        // Random files, mostly well formed, config changed only when idle
        while (sent_count < NUM_REQUESTS) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_idle();
                random_config();
            end
            src_burst = ($urandom_range(0, 3) == 0);
            make_file();
            send_file();
        end

        // Drain: everything owed, then wait out any strays
        push <= 1'b0;
        wait_cnt = 0;
        @(posedge i_clk);
        while (sb.expected_writes.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.check_leftovers();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ckb_pkg.sv
rtl/ckb_fifo.sv
rtl/ckb_front.sv
rtl/ckb_back.sv
rtl/ppm_colour_key_blitter_top.sv
dv/testbench.sv
